### rtl/core/stok_pkg.sv
// Shared constants for the stochastic oscillator %K block.
// Used by stochastic_oscillator_k; depends on nothing else.
`default_nettype none

package stok_pkg;

   // Width of the price port and of the lookback register.
   localparam int unsigned PRICE_PORT_BITS = 32;
   localparam int unsigned LOOKBACK_BITS   = 5;
   localparam logic [LOOKBACK_BITS-1:0] LOOKBACK_RESET = 5'd8;

   // %K carries 8 fraction bits, so full scale 100.0 is 25600.
   localparam int unsigned K_BITS = 15;
   localparam logic [K_BITS-1:0] K_SCALE = 15'd25600;

   // Counter for the one-bit-per-cycle divider.
   localparam int unsigned DIV_CNT_BITS = 4;

endpackage

`default_nettype wire

### rtl/core/stochastic_oscillator_k.sv
// Stochastic oscillator %K over a ring of recent price samples.
// Depends on stok_pkg for port widths, the full-scale constant and the lookback reset.
//
//  channel  | ports                                          | direction
//  ---------+------------------------------------------------+----------
//  request  | req_valid, req_ready, req_price, req_end_of_series | in
//  response | rsp_valid, rsp_ready, rsp_k_percent,           | out
//           | rsp_flat_window, rsp_is_last                   |
//  csr      | csr_we, csr_wdata (lookback)                   | in
//
// With n = min(lookback, WINDOW_DEPTH-1) earlier samples, a word that yields a result
// holds the input through the accept cycle, a scan of those samples over the
// single-port window memory, a scaling step, the restoring divider and an output step
// that waits for a free output register. A flat window skips the divider.
// A word that yields no result is absorbed in its accept cycle.
// A finished result sits in the output register; the next word is taken while it waits.
// Reset is synchronous and empties the window; the memory itself is not cleared.
`default_nettype none

module stochastic_oscillator_k #(
   parameter int unsigned WINDOW_DEPTH = 32,
   parameter int unsigned PRICE_BITS   = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [stok_pkg::PRICE_PORT_BITS-1:0] req_price,
   input  wire logic                                 req_end_of_series,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [stok_pkg::K_BITS-1:0]               rsp_k_percent,
   output logic                                      rsp_flat_window,
   output logic                                      rsp_is_last,
   input  wire logic                                 csr_we,
   input  wire logic [stok_pkg::LOOKBACK_BITS-1:0]   csr_wdata
);

   import stok_pkg::*;

   localparam int unsigned PW   = (PRICE_BITS < PRICE_PORT_BITS) ? PRICE_BITS
                                                                 : PRICE_PORT_BITS;
   localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
   localparam int unsigned FW   = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned CW   = (FW > LOOKBACK_BITS + 1) ? FW : LOOKBACK_BITS + 1;
   localparam int unsigned NUMW = PW + K_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                 state_ff, state_in;
   logic [LOOKBACK_BITS-1:0]  lookback_ff, lookback_in;
   logic [AW-1:0]             wslot_ff, wslot_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             rd_addr_ff, rd_addr_in;
   logic [AW-1:0]             remain_ff, remain_in;
   logic                      issue_ff, issue_in;
   logic [PW-1:0]             price_ff, price_in;
   logic [PW-1:0]             lo_ff, lo_in;
   logic [PW-1:0]             hi_ff, hi_in;
   logic [PW-1:0]             diff_ff, diff_in;
   logic [PW-1:0]             den_ff, den_in;
   logic [PW-1:0]             rem_ff, rem_in;
   logic [K_BITS-1:0]         num_lo_ff, num_lo_in;
   logic [K_BITS-1:0]         quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0]   div_cnt_ff, div_cnt_in;
   logic                      flat_ff, flat_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [K_BITS-1:0]         rsp_k_ff, rsp_k_in;
   logic                      rsp_flat_ff, rsp_flat_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [PW-1:0]             mem [WINDOW_DEPTH];
   logic [PW-1:0]             rd_data_ff;
   logic                      rd_en;
   logic                      accept;
   logic [PW-1:0]             price_cur;
   logic [CW-1:0]             need;
   logic [CW-1:0]             fill_next;
   logic [NUMW-1:0]           num;
   logic [PW:0]               trial;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign price_cur       = req_price[PW-1:0];
   assign rd_en           = (state_ff == ST_SCAN) && (remain_ff != '0);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_k_percent   = rsp_k_ff;
   assign rsp_flat_window = rsp_flat_ff;
   assign rsp_is_last     = rsp_last_ff;

   // 25600 = 2^14 + 2^13 + 2^10, so the scaling is three shifted adds.
   assign num = NUMW'({diff_ff, 14'b0}) + NUMW'({diff_ff, 13'b0})
              + NUMW'({diff_ff, 10'b0});

   assign trial = {rem_ff, num_lo_ff[K_BITS-1]};

   always_comb begin
      state_in     = state_ff;
      lookback_in  = csr_we ? csr_wdata : lookback_ff;
      wslot_in     = wslot_ff;
      fill_in      = fill_ff;
      rd_addr_in   = rd_addr_ff;
      remain_in    = remain_ff;
      issue_in     = 1'b0;
      price_in     = price_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      num_lo_in    = num_lo_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      flat_in      = flat_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_k_in     = rsp_k_ff;
      rsp_flat_in  = rsp_flat_ff;
      rsp_last_in  = rsp_last_ff;

      // The window holds the current sample plus lookback earlier ones, capped at the ring.
      if ((CW'(lookback_ff) + CW'(1)) > CW'(WINDOW_DEPTH)) begin
         need = CW'(WINDOW_DEPTH);
      end else begin
         need = CW'(lookback_ff) + CW'(1);
      end
      if (fill_ff < FW'(WINDOW_DEPTH)) begin
         fill_next = CW'(fill_ff) + CW'(1);
      end else begin
         fill_next = CW'(fill_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in  = FW'(fill_next);
               wslot_in = (wslot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_ff + AW'(1);
               if (req_end_of_series) begin
                  fill_in  = '0;
                  wslot_in = '0;
               end
               price_in   = price_cur;
               lo_in      = price_cur;
               hi_in      = price_cur;
               last_in    = req_end_of_series;
               rd_addr_in = (wslot_ff == '0) ? AW'(WINDOW_DEPTH - 1) : wslot_ff - AW'(1);
               remain_in  = AW'(need - CW'(1));
               if (fill_next >= need) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in   = 1'b1;
               remain_in  = remain_ff - AW'(1);
               rd_addr_in = (rd_addr_ff == '0) ? AW'(WINDOW_DEPTH - 1)
                                               : rd_addr_ff - AW'(1);
            end
            if (issue_ff) begin
               if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
               if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
            end
            if (!rd_en && !issue_ff) begin
               diff_in  = price_ff - lo_ff;
               den_in   = hi_ff - lo_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (den_ff == '0) begin
               flat_in  = 1'b1;
               quo_in   = '0;
               state_in = ST_OUT;
            end else begin
               flat_in    = 1'b0;
               rem_in     = num[NUMW-1:K_BITS];
               num_lo_in  = num[K_BITS-1:0];
               quo_in     = '0;
               div_cnt_in = DIV_CNT_BITS'(K_BITS - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle; the remainder stays below den.
            if (trial >= {1'b0, den_ff}) begin
               rem_in = PW'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[K_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[PW-1:0];
               quo_in = {quo_ff[K_BITS-2:0], 1'b0};
            end
            num_lo_in  = {num_lo_ff[K_BITS-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - DIV_CNT_BITS'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_k_in     = (quo_ff > K_SCALE) ? K_SCALE : quo_ff;
               rsp_flat_in  = flat_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lookback_ff  <= LOOKBACK_RESET;
         wslot_ff     <= '0;
         fill_ff      <= '0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lookback_ff  <= lookback_in;
         wslot_ff     <= wslot_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff  <= rd_addr_in;
      remain_ff   <= remain_in;
      price_ff    <= price_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      num_lo_ff   <= num_lo_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      flat_ff     <= flat_in;
      last_ff     <= last_in;
      rsp_k_ff    <= rsp_k_in;
      rsp_flat_ff <= rsp_flat_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Window memory: written on accept, read one earlier sample per scan cycle while samples remain.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wslot_ff] <= price_cur;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_k_ff <= K_SCALE))
      else $error("k_percent above full scale");

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flat_ff) |-> (rsp_k_ff == '0))
      else $error("flat window with nonzero k_percent");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(WINDOW_DEPTH))
      else $error("fill count beyond window depth");

endmodule

`default_nettype wire
